### src/rdq_pkg.sv
// Shared codes and defaults for the reversible deque.
package rdq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam logic [2:0] KIND_POP_BACK   = 3'd0;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd1;
  localparam logic [2:0] KIND_REVERSE    = 3'd2;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd3;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd4;

  localparam logic [1:0] ST_POPPED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

endpackage

### src/rdq_store.sv
// Entry storage: RAM with separate write and read ports and a registered read.
module rdq_store #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/reversible_deque.sv
// Top level of the reversible deque: pointer control around the entry RAM.
//
//  channel  ports                          transfer
//  in       start, busy, in_kind, in_value start && !busy at clk rise
//  out      out_valid, out_status, ...     out_valid, one cycle, no backpressure
//
// One operation per cycle; busy stays low.
// A pop result shows in the cycle after its transfer, when the registered RAM read returns its entry.
// A full-push result also shows in the cycle after its transfer.
// Reset (rst_n low, synchronous) clears pointers and orientation; the RAM is not cleared.
// The receiver cannot stall; every result is on the ports for exactly one cycle.
module reversible_deque #(
  parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_popped_value
);
  import rdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          rev_r, rev_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          pop_r, pop_nxt;

  logic          accept;
  logic          empty, full, at_head;
  logic [SW-1:0] sum_end, sum_last;
  logic [AW-1:0] end_slot, tail_slot, head_inc, head_dec;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (occ_r == '0);
  assign full   = (occ_r >= DEPTH_C);

  assign sum_end  = SW'(head_r) + SW'(occ_r);
  assign sum_last = sum_end - SW'(1);
  assign end_slot  = (sum_end >= DEPTH_S) ? AW'(sum_end - DEPTH_S) : AW'(sum_end);
  assign tail_slot = (sum_last >= DEPTH_S) ? AW'(sum_last - DEPTH_S) : AW'(sum_last);
  assign head_inc  = (head_r == LAST_A) ? '0 : head_r + AW'(1);
  assign head_dec  = (head_r == '0) ? LAST_A : head_r - AW'(1);

  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    rev_nxt       = rev_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    pop_nxt       = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = end_slot;
    raddr         = tail_slot;
    at_head       = 1'b0;
    if (accept) begin
      case (in_kind) inside
        KIND_POP_BACK, KIND_POP_FRONT: begin
          out_valid_nxt = 1'b1;
          at_head = (in_kind == KIND_POP_FRONT) != rev_r;
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_POPPED;
            pop_nxt    = 1'b1;
            re         = 1'b1;
            occ_nxt    = occ_r - CW'(1);
            if (at_head) begin
              raddr    = head_r;
              head_nxt = head_inc;
            end
          end
        end
        KIND_REVERSE: begin
          rev_nxt = !rev_r;
        end
        KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
          at_head = (in_kind == KIND_PUSH_FRONT) != rev_r;
          if (full) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_FULL;
          end else begin
            we      = 1'b1;
            occ_nxt = occ_r + CW'(1);
            if (at_head) begin
              waddr    = head_dec;
              head_nxt = head_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pop_r       <= 1'b0;
      status_r    <= ST_POPPED;
    end else begin
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
      pop_r       <= pop_nxt;
      status_r    <= status_nxt;
    end
  end

  rdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = pop_r ? $signed(rdata) : 32'sd0;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("occupancy above depth");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without transfer");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && empty && (in_kind == KIND_POP_BACK || in_kind == KIND_POP_FRONT)
    |=> out_valid && out_status == ST_EMPTY && out_popped_value == 32'sd0)
    else $error("empty pop not reported");

  a_reverse_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind == KIND_REVERSE |=> $stable(head_r) && $stable(occ_r) && !out_valid)
    else $error("reverse touched pointers");

endmodule

### verif/reversible_deque_tb.sv
// Self-checking testbench for the reversible deque: queued operations, shadow deque, result check.
`timescale 1ns / 1ps

module reversible_deque_tb;
  import rdq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned RANDOM_OPS = 1550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [2:0] kind;
    logic signed [31:0] value;
    int unsigned gap_pct;
  } deque_op_t;

  typedef struct {
    logic [1:0] status;
    logic signed [31:0] popped_value;
  } deque_reply_t;

  typedef enum int {MODE_BALANCED, MODE_GROW, MODE_NEAR_FULL, MODE_SHRINK} gen_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_kind = KIND_POP_BACK;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [31:0] out_popped_value;

  deque_op_t op_queue[$];
  deque_reply_t expected_replies[$];
  deque_op_t drv_op;
  bit took = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gen_count = 0;

  // shadow deque state
  logic signed [31:0] shadow_mem [DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_count = 0;
  bit shadow_rev = 1'b0;

  reversible_deque #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_popped_value(out_popped_value)
  );

  always #2 clk = ~clk;

  task automatic deque_apply(input logic [2:0] kind, input logic signed [31:0] value);
    deque_reply_t r;
    bit at_head;
    int unsigned slot;
    r.status = ST_POPPED;
    r.popped_value = '0;
    case (kind)
      KIND_POP_BACK, KIND_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at_head = (kind == KIND_POP_FRONT) != shadow_rev;
          if (at_head) begin
            r.popped_value = shadow_mem[shadow_head];
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            slot = (shadow_head + shadow_count - 1) % DEPTH;
            r.popped_value = shadow_mem[slot];
          end
          shadow_count--;
        end
        expected_replies = {expected_replies, r};
      end
      KIND_REVERSE: shadow_rev = !shadow_rev;
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
          expected_replies = {expected_replies, r};
        end else begin
          at_head = (kind == KIND_PUSH_FRONT) != shadow_rev;
          if (at_head) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_mem[shadow_head] = value;
          end else begin
            shadow_mem[(shadow_head + shadow_count) % DEPTH] = value;
          end
          shadow_count++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_op(input logic [2:0] kind, input logic signed [31:0] value,
                        input int unsigned gap);
    deque_op_t op;
    op.kind = kind;
    op.value = value;
    op.gap_pct = gap;
    op_queue = {op_queue, op};
    if ((kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) && gen_count < DEPTH)
      gen_count++;
    else if ((kind == KIND_POP_BACK || kind == KIND_POP_FRONT) && gen_count > 0)
      gen_count--;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // driver: one transfer per start && !busy, gaps drawn per item
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= op_queue[0].gap_pct) begin
        drv_op = op_queue.pop_front();
        start <= 1'b1;
        in_kind <= drv_op.kind;
        in_value <= drv_op.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results against the shadow deque, then predict new transfers
  always @(posedge clk) begin
    deque_reply_t exp_r;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      took = 1'b0;
      if (rst_n) begin
        if (out_valid) begin
          if (expected_replies.size() == 0) begin
            if (mismatches < 10)
              $display("%0t: unexpected result status %0d value %0d", $realtime,
                       out_status, out_popped_value);
            mismatches++;
          end else begin
            exp_r = expected_replies.pop_front();
            if (out_status !== exp_r.status || out_popped_value !== exp_r.popped_value) begin
              if (mismatches < 10)
                $display("%0t: mismatch: expected status %0d value %0d, got status %0d value %0d",
                         $realtime, exp_r.status, exp_r.popped_value, out_status,
                         out_popped_value);
              mismatches++;
            end
          end
        end
        if (start && !busy) begin
          took = 1'b1;
          deque_apply(in_kind, in_value);
        end
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned gap;
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned near_left;
    gen_mode_t mode;

    // directed: empty pops, single element, reversal, extremes, spare kinds
    add_op(KIND_POP_BACK, VAL_MAX, 19);
    add_op(KIND_POP_FRONT, VAL_MIN, 19);
    add_op(KIND_REVERSE, '0, 19);
    add_op(KIND_REVERSE, '0, 19);
    add_op(KIND_PUSH_BACK, VAL_MAX, 19);
    add_op(KIND_PUSH_FRONT, VAL_MIN, 19);
    add_op(KIND_POP_BACK, '0, 19);
    add_op(KIND_POP_BACK, '0, 19);
    add_op(KIND_PUSH_BACK, 32'sd1, 19);
    add_op(KIND_PUSH_BACK, 32'sd2, 19);
    add_op(KIND_PUSH_FRONT, -32'sd1, 19);
    add_op(KIND_REVERSE, '0, 19);
    add_op(KIND_POP_FRONT, '0, 19);
    add_op(KIND_PUSH_FRONT, 32'sd5, 19);
    add_op(KIND_POP_BACK, '0, 19);
    add_op(KIND_PUSH_BACK, '0, 19);
    add_op(KIND_POP_FRONT, '0, 19);
    add_op(KIND_SPARE_FIRST, VAL_MAX, 19);
    add_op(KIND_SPARE_LAST, -32'sd1, 19);
    add_op(KIND_SPARE_FIRST + 3'd1, VAL_MIN, 19);
    add_op(KIND_POP_FRONT, '0, 19);
    add_op(KIND_REVERSE, '0, 19);
    add_op(KIND_POP_BACK, '0, 19);
    add_op(KIND_POP_FRONT, '0, 19);

    // random: balanced, then fill to full, hover at full, then drain
    counted = 0;
    near_left = 30;
    mode = MODE_BALANCED;
    while (counted < RANDOM_OPS || mode == MODE_GROW || mode == MODE_NEAR_FULL) begin
      gap = (counted < RANDOM_OPS / 3) ? 19 : (counted < 2 * RANDOM_OPS / 3) ? 62 : 0;
      if (mode == MODE_BALANCED && counted >= 250) mode = MODE_GROW;
      if (mode == MODE_GROW && gen_count == DEPTH) mode = MODE_NEAR_FULL;
      if (mode == MODE_NEAR_FULL && near_left == 0) mode = MODE_SHRINK;
      case (mode)
        MODE_BALANCED: begin push_pct = 45; pop_pct = 43; end
        MODE_GROW: begin push_pct = 94; pop_pct = 3; end
        MODE_NEAR_FULL: begin push_pct = 60; pop_pct = 20; end
        default: begin push_pct = 10; pop_pct = 82; end
      endcase
      roll = $urandom_range(99);
      if ($urandom_range(99) < 2) begin
        add_op(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)), rand_value(), gap);
      end else begin
        if (roll < push_pct)
          add_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, rand_value(), gap);
        else if (roll < push_pct + pop_pct)
          add_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK, rand_value(), gap);
        else
          add_op(KIND_REVERSE, rand_value(), gap);
        counted++;
        if (mode == MODE_NEAR_FULL) near_left--;
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || start) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
